// ===== sv/gha_pkg.sv =====
`default_nettype none

package gha_pkg;

  localparam int SLOT_COUNT_DEF = 1024;
  localparam int GEN_BITS_DEF   = 16;

  // fixed field widths of the request and response beats
  localparam int ACT_LEN   = 2;
  localparam int IDX_LEN   = 10;
  localparam int GEN_LEN   = 16;
  localparam int COUNT_LEN = 11;

  localparam logic [ACT_LEN-1:0] ACT_CREATE  = 2'd0;
  localparam logic [ACT_LEN-1:0] ACT_DESTROY = 2'd1;
  localparam logic [ACT_LEN-1:0] ACT_CHECK   = 2'd2;

  typedef struct packed {
    logic [ACT_LEN-1:0] action;
    logic [IDX_LEN-1:0] handle_index;
    logic [GEN_LEN-1:0] handle_generation;
  } in_t;

  typedef struct packed {
    logic [IDX_LEN-1:0]   new_index;
    logic [GEN_LEN-1:0]   new_generation;
    logic                 success;
    logic                 table_full;
    logic [COUNT_LEN-1:0] live_count;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic pop_rd;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic create_pop;
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/gha_ctrl.sv =====
`default_nettype none

module gha_ctrl (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire gha_pkg::sts_t sts,
  output gha_pkg::cmd_t    cmd,
  output logic             busy
);
  import gha_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      S_IDLE: begin
        // no request is taken while reset is held
        busy = !rst_n;
        if (start && rst_n) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        // create from the free stack needs a second read for the generation
        if (sts.create_pop) begin
          cmd.pop_rd = 1'b1;
          state_nxt  = S_POP;
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_POP: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/gha_dp.sv =====
`default_nettype none

module gha_dp #(
  parameter int SLOT_COUNT = gha_pkg::SLOT_COUNT_DEF,
  parameter int GEN_BITS   = gha_pkg::GEN_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire gha_pkg::cmd_t cmd,
  input  wire gha_pkg::in_t  in_data,
  output gha_pkg::sts_t      sts,
  output logic               out_valid,
  output gha_pkg::out_t      out_data
);
  import gha_pkg::*;

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int CW    = (CNT_W > IDX_LEN) ? CNT_W : IDX_LEN;
  localparam int GW    = (GEN_BITS > GEN_LEN) ? GEN_BITS : GEN_LEN;

  logic [GEN_BITS-1:0] gen_mem [SLOT_COUNT];
  logic [IDX_W-1:0]    stack_mem [SLOT_COUNT];

  logic [ACT_LEN-1:0]  act_r;
  logic [IDX_LEN-1:0]  idx_r;
  logic [GEN_LEN-1:0]  hgen_r;
  logic [GEN_BITS-1:0] gen_q;
  logic [IDX_W-1:0]    stk_q;

  logic [CNT_W-1:0] used_r, used_nxt;
  logic [CNT_W-1:0] depth_r, depth_nxt;
  logic [CNT_W-1:0] alive_r, alive_nxt;
  logic             out_valid_r;
  out_t             out_data_r, out_data_nxt;

  logic                is_create, is_destroy;
  logic                stack_nonempty, room, stack_room, alive;
  logic                gen_we, push, rd_en;
  logic [IDX_W-1:0]    gen_wa, rd_addr;
  logic [GEN_BITS-1:0] gen_wd;

  assign is_create      = (act_r == ACT_CREATE);
  assign is_destroy     = (act_r == ACT_DESTROY);
  assign stack_nonempty = (depth_r != '0);
  assign room           = (used_r < CNT_W'(SLOT_COUNT));
  assign stack_room     = (depth_r < CNT_W'(SLOT_COUNT));
  assign sts.create_pop = is_create && stack_nonempty;

  // index below the high-water mark, generation match, generation nonzero
  assign alive = (CW'(idx_r) < CW'(used_r)) && (GW'(gen_q) == GW'(hgen_r)) &&
                 (hgen_r != '0);

  assign gen_we = cmd.exec && ((is_create && !stack_nonempty && room) ||
                               (is_destroy && alive && stack_room));
  assign push   = gen_we && is_destroy;
  assign gen_wa = is_create ? IDX_W'(used_r) : IDX_W'(idx_r);
  assign gen_wd = is_create ? GEN_BITS'(1) : gen_q + GEN_BITS'(1);

  assign rd_en   = cmd.capture || cmd.pop_rd;
  assign rd_addr = cmd.pop_rd ? stk_q : IDX_W'(in_data.handle_index);

  always_ff @(posedge clk) begin
    if (gen_we) begin
      gen_mem[gen_wa] <= gen_wd;
    end
    if (rd_en) begin
      gen_q <= gen_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      stack_mem[IDX_W'(depth_r)] <= IDX_W'(idx_r);
    end
    if (cmd.capture) begin
      stk_q <= stack_mem[IDX_W'(depth_r - CNT_W'(1))];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r  <= in_data.action;
      idx_r  <= in_data.handle_index;
      hgen_r <= in_data.handle_generation;
    end
  end

  always_comb begin
    used_nxt  = used_r;
    depth_nxt = depth_r;
    alive_nxt = alive_r;
    if (cmd.exec) begin
      case (act_r)
        ACT_CREATE: begin
          if (stack_nonempty) begin
            depth_nxt = depth_r - CNT_W'(1);
            alive_nxt = alive_r + CNT_W'(1);
          end else if (room) begin
            used_nxt  = used_r + CNT_W'(1);
            alive_nxt = alive_r + CNT_W'(1);
          end
        end
        ACT_DESTROY: begin
          if (alive && stack_room) begin
            depth_nxt = depth_r + CNT_W'(1);
            if (alive_r != '0) begin
              alive_nxt = alive_r - CNT_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_data_nxt            = '0;
    out_data_nxt.live_count = COUNT_LEN'(alive_nxt);
    if (!cmd.exec) begin
      // finishing a create taken from the free stack
      out_data_nxt.new_index      = IDX_LEN'(stk_q);
      out_data_nxt.new_generation = GEN_LEN'(gen_q);
      out_data_nxt.success        = 1'b1;
    end else begin
      case (act_r)
        ACT_CREATE: begin
          if (room) begin
            out_data_nxt.new_index      = IDX_LEN'(used_r);
            out_data_nxt.new_generation = GEN_LEN'(1);
            out_data_nxt.success        = 1'b1;
          end else begin
            out_data_nxt.table_full = 1'b1;
          end
        end
        ACT_DESTROY: begin
          out_data_nxt.success = alive && stack_room;
        end
        ACT_CHECK: begin
          out_data_nxt.success = alive;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      depth_r     <= '0;
      alive_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      depth_r     <= depth_nxt;
      alive_r     <= alive_nxt;
      out_valid_r <= cmd.finish;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== sv/generational_handle_allocator.sv =====
// Generational handle allocator: create, destroy or check-alive requests.
// Request: drive in_data with start; the beat is taken at a clock edge where
// start is high and busy is low. busy stays high while a request is at work.
// Response: out_data is shown for exactly one cycle with out_valid high; the
// receiver takes it at the end of that cycle and cannot hold it off.
// Steps: the accept edge registers the request; the exec state updates the
// memories and counters; a create that reuses a slot from the free stack
// then passes through the pop state, where the generation memory is read
// again once the stack top is known; the response is then registered with
// out_valid as the request finishes. busy drops in the cycle the response is
// shown, so a new request may be accepted at the edge that takes it, and no
// new request is taken before the last one is through.
// Reset clears the slot high-water mark, the free stack depth and the live
// count, and busy stays high while it is held; the generation and free stack
// memories are not cleared, as data read from unwritten entries goes unused.
`default_nettype none

module generational_handle_allocator #(
  parameter int SLOT_COUNT = gha_pkg::SLOT_COUNT_DEF,
  parameter int GEN_BITS   = gha_pkg::GEN_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  input  wire gha_pkg::in_t in_data,
  output logic              out_valid,
  output gha_pkg::out_t     out_data
);
  import gha_pkg::*;

  cmd_t cmd;
  sts_t sts;

  gha_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  gha_dp #(
    .SLOT_COUNT (SLOT_COUNT),
    .GEN_BITS   (GEN_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
